[design/oskt_pkg.sv]
package oskt_pkg;
  localparam int NUM_SLOTS_DEF = 8;
  localparam logic [15:0] DELAY_RESET = 16'd1000;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    FN_PRESS = 2'd0, FN_RELEASE = 2'd1, FN_CHANGE = 2'd2, FN_TICK = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0, ACT_PRESS = 2'd1, ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE, BK_SCAN, BK_EMIT
  } bk_state_e;

  typedef struct packed {
    func_e       func;
    logic [9:0]  key_position;
    logic [31:0] bind_param_one;
    logic [31:0] bind_param_two;
    logic        key_down;
    logic [31:0] event_time_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  out_position;
    logic [31:0] out_param_one;
    logic [31:0] out_param_two;
    logic [31:0] action_time_ms;
    logic [1:0]  status;
    logic        last_of_run;
  } res_t;
endpackage

[design/oskt_if.sv]
interface oskt_in_if import oskt_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface oskt_out_if import oskt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/oskt_queue.sv]
module oskt_queue import oskt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_data_o
);
  cmd_t mem_q [QDEPTH];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = cnt_q != 2'(QDEPTH);
  assign out_valid_o = cnt_q != 2'd0;
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDEPTH)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count step");
`endif
endmodule

[design/oskt_engine.sv]
module oskt_engine import oskt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] delay_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  logic [NUM_SLOTS-1:0] valid_q, let_go_q, armed_q, mod_seen_q;
  logic [9:0]  pos_q  [NUM_SLOTS];
  logic [31:0] p1_q   [NUM_SLOTS];
  logic [31:0] p2_q   [NUM_SLOTS];
  logic [31:0] dl_q   [NUM_SLOTS];
  logic [9:0]  mpos_q [NUM_SLOTS];

  bk_state_e state_q, state_d;
  cmd_t cmd_q;
  logic [CW-1:0] idx_q;
  logic [SW-1:0] si;
  logic found_q;
  logic pend_q;
  res_t pend_r_q;
  res_t out_q;
  logic out_v_q;

  assign si = idx_q[SW-1:0];
  assign cmd_ready_o = state_q == BK_IDLE;
  assign res_valid_o = out_v_q;
  assign res_o = out_q;

  logic [32:0] dl_sum;
  logic [31:0] dl_sat;
  assign dl_sum = {1'b0, cmd_q.event_time_ms} + {17'd0, delay_i};
  assign dl_sat = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];

  logic out_free;
  assign out_free = !out_v_q || res_ready_i;
  logic scan_done;
  assign scan_done = idx_q == CW'(NUM_SLOTS);

  // per-slot decision in the scan state
  logic hit;
  res_t hit_r;
  always_comb begin
    hit = 1'b0;
    hit_r = '0;
    hit_r.action = ACT_RELEASE;
    hit_r.out_position = pos_q[si];
    hit_r.out_param_one = p1_q[si];
    hit_r.out_param_two = p2_q[si];
    hit_r.action_time_ms = cmd_q.event_time_ms;
    hit_r.status = ST_OK;
    if (state_q == BK_SCAN && !scan_done) begin
      unique case (cmd_q.func)
        FN_CHANGE: if (valid_q[si] && pos_q[si] != cmd_q.key_position) begin
          if (let_go_q[si] && cmd_q.event_time_ms > dl_q[si]) begin
            hit = 1'b1;
            hit_r.action_time_ms = dl_q[si];
          end else if (!cmd_q.key_down && mod_seen_q[si] &&
                       mpos_q[si] == cmd_q.key_position && let_go_q[si]) begin
            hit = 1'b1;
          end
        end
        FN_TICK: hit = valid_q[si] && armed_q[si] && cmd_q.event_time_ms >= dl_q[si];
        default: hit = 1'b0;
      endcase
    end
  end

  // final item of a run and the single item of a press or a failed release
  res_t last_r;
  res_t fin_r;
  always_comb begin
    last_r = pend_r_q;
    last_r.last_of_run = 1'b1;
    fin_r = '0;
    fin_r.out_position = cmd_q.key_position;
    fin_r.last_of_run = 1'b1;
    if (cmd_q.func == FN_PRESS) begin
      if (found_q) begin
        fin_r.action = ACT_PRESS;
        fin_r.out_param_one = cmd_q.bind_param_one;
        fin_r.out_param_two = cmd_q.bind_param_two;
        fin_r.action_time_ms = cmd_q.event_time_ms;
      end else fin_r.status = ST_FULL;
    end else fin_r.status = ST_NOT_FOUND;
  end

  logic emit_hit, emit_last, emit_fin, emit_any;
  assign emit_hit = state_q == BK_SCAN && !scan_done && hit && pend_q && out_free;
  assign emit_last = state_q == BK_SCAN && scan_done && pend_q && out_free;
  assign emit_fin = state_q == BK_EMIT && out_free;
  assign emit_any = emit_hit || emit_last || emit_fin;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (cmd_valid_i) state_d = BK_SCAN;
      BK_SCAN: if (scan_done) begin
        if (pend_q) begin
          if (out_free) state_d = BK_IDLE;
        end else if (cmd_q.func == FN_PRESS || (cmd_q.func == FN_RELEASE && !found_q)) begin
          state_d = BK_EMIT;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_EMIT: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && cmd_valid_i) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= '0;
      let_go_q <= '0;
      armed_q <= '0;
      mod_seen_q <= '0;
      idx_q <= '0;
      found_q <= 1'b0;
      pend_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= emit_any || (out_v_q && !res_ready_i);
      unique case (state_q)
        BK_IDLE: begin
          idx_q <= '0;
          found_q <= 1'b0;
          pend_q <= 1'b0;
        end
        BK_SCAN: begin
          if (!scan_done) begin
            // press and release act only on the first match
            unique case (cmd_q.func)
              FN_PRESS: if (!valid_q[si] && !found_q) begin
                found_q <= 1'b1;
                valid_q[si] <= 1'b1;
                let_go_q[si] <= 1'b0;
                armed_q[si] <= 1'b0;
                mod_seen_q[si] <= 1'b0;
              end
              FN_RELEASE: if (valid_q[si] && pos_q[si] == cmd_q.key_position
                              && !found_q) begin
                found_q <= 1'b1;
                if (mod_seen_q[si]) begin
                  valid_q[si] <= 1'b0;
                  let_go_q[si] <= 1'b0;
                  armed_q[si] <= 1'b0;
                  mod_seen_q[si] <= 1'b0;
                  pend_q <= 1'b1;
                end else begin
                  let_go_q[si] <= 1'b1;
                  armed_q[si] <= dl_sat > cmd_q.event_time_ms;
                end
              end
              FN_CHANGE: if (!hit && cmd_q.key_down && valid_q[si] &&
                             pos_q[si] != cmd_q.key_position && !mod_seen_q[si]) begin
                mod_seen_q[si] <= 1'b1;
                if (let_go_q[si]) armed_q[si] <= 1'b0;
              end
              default: ;
            endcase
            if (hit) begin
              if (!pend_q || out_free) begin
                valid_q[si] <= 1'b0;
                let_go_q[si] <= 1'b0;
                armed_q[si] <= 1'b0;
                mod_seen_q[si] <= 1'b0;
                idx_q <= idx_q + 1'b1;
                pend_q <= 1'b1;
              end
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else if (pend_q && out_free) begin
            pend_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload side of the scan
  always_ff @(posedge clk_i) begin
    if (state_q == BK_SCAN && !scan_done) begin
      if (cmd_q.func == FN_PRESS && !valid_q[si] && !found_q) begin
        pos_q[si] <= cmd_q.key_position;
        p1_q[si] <= cmd_q.bind_param_one;
        p2_q[si] <= cmd_q.bind_param_two;
        dl_q[si] <= '0;
        mpos_q[si] <= '0;
      end
      if (cmd_q.func == FN_RELEASE && valid_q[si] && pos_q[si] == cmd_q.key_position
          && !found_q && !mod_seen_q[si]) dl_q[si] <= dl_sat;
      if (cmd_q.func == FN_RELEASE && valid_q[si] && pos_q[si] == cmd_q.key_position
          && !found_q && mod_seen_q[si]) pend_r_q <= hit_r;
      if (cmd_q.func == FN_CHANGE && !hit && cmd_q.key_down && valid_q[si] &&
          pos_q[si] != cmd_q.key_position && !mod_seen_q[si]) mpos_q[si] <= cmd_q.key_position;
      if (hit && (!pend_q || out_free)) pend_r_q <= hit_r;
    end
    if (emit_hit) out_q <= pend_r_q;
    else if (emit_last) out_q <= last_r;
    else if (emit_fin) out_q <= fin_r;
  end

`ifndef ASSERT_OFF
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_ready_i) |=> out_v_q) else $error("result dropped");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_ready_i) |=> $stable(out_q)) else $error("result changed");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CW'(NUM_SLOTS)) else $error("scan index out of range");
`endif
endmodule

[design/one_shot_key_tracker_unit.sv]
// One-shot key tracker with NUM_SLOTS slots. A front queue of two entries takes
// items while the back engine scans the slot table one slot a cycle, except where
// a hit waits for the result side to take the previous result; a press or release
// finds its slot in the same scan. The release delay register sits at address 0
// and resets to 1000 ms.
module one_shot_key_tracker_unit import oskt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  oskt_in_if.sink     in_if,
  oskt_out_if.source  out_if
);
  logic [15:0] delay_q;
  cmd_t q_data;
  logic q_valid, q_ready;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {16'd0, delay_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) delay_q <= DELAY_RESET;
    else if (psel && penable && pwrite && paddr == 1'b0) delay_q <= pwdata[15:0];
  end

  oskt_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  oskt_engine #(.NUM_SLOTS(NUM_SLOTS)) u_engine (
    .clk_i, .rst_ni, .delay_i(delay_q),
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_data),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_o(out_if.data)
  );
endmodule

[verif/one_shot_key_tracker_unit_test.sv]
module one_shot_key_tracker_unit_test import oskt_pkg::*; ();

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int MAX_RUN = 8;
  localparam logic [0:0] ADDR_DELAY = 1'b0;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  oskt_in_if key_ev ();
  oskt_out_if key_act ();

  one_shot_key_tracker_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_if(key_ev.sink), .out_if(key_act.source)
  );

  // tracker mirror
  logic [15:0] delay_ms;
  logic        sv_valid [SLOTS];
  logic [9:0]  sv_pos [SLOTS];
  logic [31:0] sv_p1 [SLOTS];
  logic [31:0] sv_p2 [SLOTS];
  logic [31:0] sv_dl [SLOTS];
  logic        sv_let_go [SLOTS];
  logic        sv_armed [SLOTS];
  logic        sv_mod_seen [SLOTS];
  logic [9:0]  sv_mod_pos [SLOTS];

  res_t pending_actions [$];
  int   fails = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   recv_hold = 1'b0;
  int   idle_cycles = 0;
  logic [31:0] clock_ms = 32'd0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic res_t make_action(action_e a, logic [9:0] p, logic [31:0] p1,
                                       logic [31:0] p2, logic [31:0] t, status_e st);
    res_t r;
    r.action = a;
    r.out_position = p;
    r.out_param_one = p1;
    r.out_param_two = p2;
    r.action_time_ms = t;
    r.status = st;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic free_slot(int s, logic [31:0] t, ref res_t run [$]);
    run.push_back(make_action(ACT_RELEASE, sv_pos[s], sv_p1[s], sv_p2[s], t, ST_OK));
    sv_valid[s] = 1'b0;
    sv_let_go[s] = 1'b0;
    sv_armed[s] = 1'b0;
    sv_mod_seen[s] = 1'b0;
  endtask

  task automatic predict_key_event(cmd_t c);
    res_t run [$];
    int s;
    logic [32:0] sum;
    logic [31:0] dl;
    s = 0;
    case (c.func)
      FN_PRESS: begin
        while (s < SLOTS && sv_valid[s]) s++;
        if (s == SLOTS) begin
          run.push_back(make_action(ACT_NONE, c.key_position, '0, '0, '0, ST_FULL));
        end else begin
          sv_valid[s] = 1'b1;
          sv_pos[s] = c.key_position;
          sv_p1[s] = c.bind_param_one;
          sv_p2[s] = c.bind_param_two;
          sv_dl[s] = '0;
          sv_let_go[s] = 1'b0;
          sv_armed[s] = 1'b0;
          sv_mod_seen[s] = 1'b0;
          sv_mod_pos[s] = '0;
          run.push_back(make_action(ACT_PRESS, c.key_position, c.bind_param_one,
                                    c.bind_param_two, c.event_time_ms, ST_OK));
        end
      end
      FN_RELEASE: begin
        while (s < SLOTS && !(sv_valid[s] && sv_pos[s] == c.key_position)) s++;
        if (s == SLOTS) begin
          run.push_back(make_action(ACT_NONE, c.key_position, '0, '0, '0, ST_NOT_FOUND));
        end else if (sv_mod_seen[s]) begin
          free_slot(s, c.event_time_ms, run);
        end else begin
          sum = {1'b0, c.event_time_ms} + {17'd0, delay_ms};
          dl = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          sv_dl[s] = dl;
          sv_let_go[s] = 1'b1;
          sv_armed[s] = dl > c.event_time_ms;
        end
      end
      FN_CHANGE: begin
        for (s = 0; s < SLOTS && run.size() < MAX_RUN; s++) begin
          if (!sv_valid[s] || sv_pos[s] == c.key_position) continue;
          if (sv_let_go[s] && c.event_time_ms > sv_dl[s]) begin
            free_slot(s, sv_dl[s], run);
            continue;
          end
          if (c.key_down) begin
            if (sv_mod_seen[s]) continue;
            sv_mod_seen[s] = 1'b1;
            sv_mod_pos[s] = c.key_position;
            if (sv_let_go[s]) sv_armed[s] = 1'b0;
          end else if (sv_mod_seen[s] && sv_mod_pos[s] == c.key_position && sv_let_go[s]) begin
            free_slot(s, c.event_time_ms, run);
          end
        end
      end
      default: begin
        for (s = 0; s < SLOTS && run.size() < MAX_RUN; s++)
          if (sv_valid[s] && sv_armed[s] && c.event_time_ms >= sv_dl[s])
            free_slot(s, c.event_time_ms, run);
      end
    endcase
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) pending_actions.push_back(run[i]);
  endtask

  // valid stays high after an item so the next one can follow at once;
  // drain takes it low
  task automatic send_event(func_e f, logic [9:0] pos, logic [31:0] t, logic down = 1'b0,
                            logic [31:0] p1 = 32'h0, logic [31:0] p2 = 32'h0);
    cmd_t c;
    c.func = f;
    c.key_position = pos;
    c.bind_param_one = p1;
    c.bind_param_two = p2;
    c.key_down = down;
    c.event_time_ms = t;
    while ($urandom_range(99) < send_idle_pct) begin
      key_ev.valid <= 1'b0;
      @(posedge clk_i);
    end
    key_ev.valid <= 1'b1;
    key_ev.data <= c;
    @(posedge clk_i);
    while (!key_ev.ready) @(posedge clk_i);
    predict_key_event(c);
  endtask

  task automatic drain();
    key_ev.valid <= 1'b0;
    while (pending_actions.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_delay(logic [15:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_DELAY;
    pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    delay_ms = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (key_act.valid && key_act.ready) begin
        if (pending_actions.size() == 0) begin
          $error("unexpected action item %p", key_act.data);
          fails++;
        end else begin
          res_t e;
          e = pending_actions.pop_front();
          if (key_act.data.action !== e.action) begin
            $error("action exp %0d got %0d", e.action, key_act.data.action); fails++;
          end
          if (key_act.data.out_position !== e.out_position) begin
            $error("out_position exp %0d got %0d", e.out_position, key_act.data.out_position);
            fails++;
          end
          if (key_act.data.out_param_one !== e.out_param_one) begin
            $error("out_param_one exp %h got %h", e.out_param_one, key_act.data.out_param_one);
            fails++;
          end
          if (key_act.data.out_param_two !== e.out_param_two) begin
            $error("out_param_two exp %h got %h", e.out_param_two, key_act.data.out_param_two);
            fails++;
          end
          if (key_act.data.action_time_ms !== e.action_time_ms) begin
            $error("action_time_ms exp %h got %h", e.action_time_ms,
                   key_act.data.action_time_ms);
            fails++;
          end
          if (key_act.data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, key_act.data.status); fails++;
          end
          if (key_act.data.last_of_run !== e.last_of_run) begin
            $error("last_of_run exp %0d got %0d", e.last_of_run, key_act.data.last_of_run);
            fails++;
          end
        end
      end
      key_act.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((key_ev.valid && key_ev.ready) || (key_act.valid && key_act.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] t;
    t = 32'd100;
    send_event(FN_RELEASE, 10'd5, t);
    for (int i = 0; i < SLOTS; i++)
      send_event(FN_PRESS, 10'(i * 100 + 3), t, 1'b0, 32'hFFFF_FFFF - i, 32'(i));
    send_event(FN_PRESS, 10'h3FF, t, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(FN_CHANGE, 10'd900, t, 1'b1);
    send_event(FN_RELEASE, 10'd3, 32'd200);
    send_event(FN_CHANGE, 10'd900, 32'd210, 1'b0);
    send_event(FN_RELEASE, 10'd103, 32'd300);
    send_event(FN_RELEASE, 10'd203, 32'd300);
    send_event(FN_TICK, 10'd0, 32'd1299);
    send_event(FN_CHANGE, 10'd1, 32'd1300, 1'b1);
    send_event(FN_TICK, 10'd0, 32'hFFFF_FFFF);
    send_event(FN_RELEASE, 10'd303, 32'hFFFF_FF00);
    send_event(FN_CHANGE, 10'd2, 32'hFFFF_FFFF, 1'b0);
    send_event(FN_TICK, 10'd0, 32'hFFFF_FFFF);
    send_event(FN_CHANGE, 10'd900, 32'hFFFF_FFFF, 1'b0);
    drain();
    for (int i = 0; i < SLOTS; i++) send_event(FN_RELEASE, 10'(i * 100 + 3), 32'h0);
    send_event(FN_TICK, 10'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_delay();
    write_delay(16'd0);
    send_event(FN_PRESS, 10'd7, 32'd50, 1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_event(FN_RELEASE, 10'd7, 32'd60);
    send_event(FN_TICK, 10'd0, 32'hFFFF_FFFF);
    send_event(FN_CHANGE, 10'd8, 32'd61, 1'b1);
    drain();
  endtask

  task automatic random_sequences(int n);
    logic [9:0] keys [4];
    logic [9:0] k;
    for (int i = 0; i < 4; i++) keys[i] = 10'($urandom);
    for (int i = 0; i < n; i++) begin
      k = keys[$urandom_range(3)];
      clock_ms = clock_ms + $urandom_range(delay_ms > 0 ? 2 * delay_ms : 20);
      case ($urandom_range(9))
        0, 1: send_event(FN_PRESS, k, clock_ms, 1'($urandom), $urandom, $urandom);
        2, 3: send_event(FN_RELEASE, k, clock_ms, 1'($urandom));
        4, 5, 6: send_event(FN_CHANGE, 10'($urandom_range(3)), clock_ms, 1'($urandom));
        7: send_event(FN_TICK, 10'($urandom), clock_ms);
        8: send_event(FN_CHANGE, k, clock_ms, 1'($urandom));
        default: send_event(func_e'($urandom_range(3)), 10'($urandom), $urandom,
                            1'($urandom), $urandom, $urandom);
      endcase
    end
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_event(FN_PRESS, 10'(i), clock_ms, 1'b0, $urandom, $urandom);
    join
    drain();
    for (int i = 0; i < 12; i++) send_event(FN_RELEASE, 10'(i), clock_ms);
    send_event(FN_TICK, 10'd0, 32'hFFFF_FFFF);
    drain();
  endtask

  initial begin
    key_ev.valid = 1'b0;
    key_ev.data = '0;
    key_act.ready = 1'b0;
    delay_ms = DELAY_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      sv_valid[i] = 1'b0; sv_let_go[i] = 1'b0; sv_armed[i] = 1'b0; sv_mod_seen[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_delay();
    test_backpressure();
    write_delay(16'd40);
    send_idle_pct = 22; recv_idle_pct = 73;
    random_sequences(80);
    write_delay(16'hFFFF);
    clock_ms = 32'hFFF0_0000;
    send_idle_pct = 73; recv_idle_pct = 22;
    random_sequences(40);
    write_delay(16'd1);
    clock_ms = 32'd0;
    random_sequences(40);
    write_delay(16'd25);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_sequences(40);
    drain();
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

[sim.f]
design/oskt_pkg.sv
design/oskt_if.sv
design/oskt_queue.sv
design/oskt_engine.sv
design/one_shot_key_tracker_unit.sv
verif/one_shot_key_tracker_unit_test.sv
